// File: src/output_test_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the output test sequencer
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef OUTPUT_TEST_SEQUENCER_ASSERT_SVH
`define OUTPUT_TEST_SEQUENCER_ASSERT_SVH

// same-cycle implication, off while reset is active
`define OTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("output_test_sequencer: assertion failed");

// next-cycle implication, off while reset is active
`define OTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("output_test_sequencer: assertion failed");

// next-cycle implication, also checked during reset
`define OTS_ASSERT_ALW(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("output_test_sequencer: assertion failed");

`endif

// File: src/ots_pkg.sv
// ----------------------------------------------------------------------------
// ots_pkg
// Shared constants, command codes, register indexes and item type.
// ----------------------------------------------------------------------------
package ots_pkg;

    localparam int OUTPUT_COUNT_DEFAULT = 10;

    localparam int CMD_W       = 3;
    localparam int INDEX_W     = 4;
    localparam int REQ_W       = 16;
    localparam int PHASE_W     = 16;
    localparam int PULSE_W     = 14;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int ITEM_W      = CMD_W + INDEX_W + REQ_W;
    localparam int IN_DATA_W   = ((ITEM_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ON      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_OFF     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PULSE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ALL_ON  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ALL_OFF = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RESUME  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_ON_TICKS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TICKS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_PULSE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE     = 2'd3;

    localparam logic [PHASE_W-1:0] ON_TICKS_RESET      = 16'd1000;
    localparam logic [PHASE_W-1:0] OFF_TICKS_RESET     = 16'd1000;
    localparam logic [PULSE_W-1:0] DEFAULT_PULSE_RESET = 14'd500;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RESET     = 14'd10000;

    typedef struct packed {
        logic [REQ_W-1:0]   pulse_length;
        logic [INDEX_W-1:0] output_index;
        logic [CMD_W-1:0]   cmd;
    } item_t;

endpackage

// File: src/ots_input_stage.sv
// ----------------------------------------------------------------------------
// ots_input_stage
// Input register: captures one transaction and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module ots_input_stage
    import ots_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 consume,
    output logic                 item_valid,
    output item_t                item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign s_tready   = !valid_reg || consume;
    assign load       = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_t'(s_tdata[ITEM_W-1:0]);
        end
    end

endmodule

// File: src/ots_core.sv
// ----------------------------------------------------------------------------
// ots_core
// Sequencer state, configuration registers and the per-transaction update.
// ----------------------------------------------------------------------------
module ots_core
    import ots_pkg::*;
#(
    parameter int OUTPUT_COUNT = OUTPUT_COUNT_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                    advance,
    input  item_t                   item,
    output logic [OUTPUT_COUNT-1:0] res_levels,
    output logic                    res_auto,
    output logic [INDEX_W-1:0]      res_walk,
    output logic                    res_status
);

    localparam int CNT_W  = $clog2(OUTPUT_COUNT + 1);
    localparam int WALK_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    logic [PHASE_W-1:0] on_ticks_reg;
    logic [PHASE_W-1:0] off_ticks_reg;
    logic [PULSE_W-1:0] default_pulse_reg;
    logic [PULSE_W-1:0] max_pulse_reg;

    logic [OUTPUT_COUNT-1:0] level_reg,  level_next;
    logic                    auto_reg,   auto_next;
    logic [WALK_W-1:0]       walk_reg,   walk_next;
    logic                    phase_reg,  phase_next;
    logic [PHASE_W-1:0]      count_reg,  count_next;
    logic [PULSE_W-1:0]      pulse_reg  [OUTPUT_COUNT];
    logic [PULSE_W-1:0]      pulse_next [OUTPUT_COUNT];

    logic                    status;
    logic [PHASE_W-1:0]      count_inc;
    logic [WALK_W-1:0]       walk_adv;
    logic [WALK_W-1:0]       idx_ext;
    logic                    idx_ok;
    logic [OUTPUT_COUNT-1:0] walk_hot;
    logic [OUTPUT_COUNT-1:0] adv_hot;
    logic [OUTPUT_COUNT-1:0] idx_hot;
    logic [REQ_W-1:0]        req_len;
    logic [PULSE_W-1:0]      pulse_len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_ticks_reg      <= ON_TICKS_RESET;
            off_ticks_reg     <= OFF_TICKS_RESET;
            default_pulse_reg <= DEFAULT_PULSE_RESET;
            max_pulse_reg     <= MAX_PULSE_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_ON_TICKS:      on_ticks_reg      <= cfg_wdata;
                REG_OFF_TICKS:     off_ticks_reg     <= cfg_wdata;
                REG_DEFAULT_PULSE: default_pulse_reg <= cfg_wdata[PULSE_W-1:0];
                REG_MAX_PULSE:     max_pulse_reg     <= cfg_wdata[PULSE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign count_inc = count_reg + PHASE_W'(1);
    assign walk_adv  = (walk_reg >= WALK_W'(OUTPUT_COUNT)) ? WALK_W'(1)
                                                           : walk_reg + WALK_W'(1);
    assign idx_ext   = WALK_W'(item.output_index);
    assign idx_ok    = (idx_ext >= WALK_W'(1)) && (idx_ext <= WALK_W'(OUTPUT_COUNT));

    always_comb begin
        for (int i = 0; i < OUTPUT_COUNT; i++) begin
            walk_hot[i] = (walk_reg == WALK_W'(i + 1));
            adv_hot[i]  = (walk_adv == WALK_W'(i + 1));
            idx_hot[i]  = (idx_ext  == WALK_W'(i + 1));
        end
    end

    always_comb begin
        req_len = item.pulse_length;
        if (req_len == '0 || req_len > REQ_W'(max_pulse_reg)) begin
            req_len = REQ_W'(default_pulse_reg);
        end
        if (req_len == '0) begin
            req_len = REQ_W'(1);
        end
        pulse_len = req_len[PULSE_W-1:0];
    end

    always_comb begin
        level_next = level_reg;
        auto_next  = auto_reg;
        walk_next  = walk_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        pulse_next = pulse_reg;
        status     = 1'b0;
        case (item.cmd)
            CMD_TICK: begin
                for (int i = 0; i < OUTPUT_COUNT; i++) begin
                    if (pulse_reg[i] != '0) begin
                        pulse_next[i] = pulse_reg[i] - PULSE_W'(1);
                        if (pulse_reg[i] == PULSE_W'(1)) begin
                            level_next[i] = 1'b0;
                        end
                    end
                end
                if (auto_reg) begin
                    count_next = count_inc;
                    if (!phase_reg) begin
                        if (count_inc >= on_ticks_reg || count_inc == '0) begin
                            level_next = level_next & ~walk_hot;
                            phase_next = 1'b1;
                            count_next = '0;
                        end
                    end else if (count_inc >= off_ticks_reg || count_inc == '0) begin
                        walk_next  = walk_adv;
                        level_next = level_next | adv_hot;
                        phase_next = 1'b0;
                        count_next = '0;
                    end
                end
            end
            CMD_ON, CMD_OFF, CMD_PULSE: begin
                if (!idx_ok) begin
                    status = 1'b1;
                end else begin
                    if (auto_reg) begin
                        auto_next  = 1'b0;
                        level_next = '0;
                    end
                    if (item.cmd == CMD_OFF) begin
                        level_next = level_next & ~idx_hot;
                    end else begin
                        level_next = level_next | idx_hot;
                    end
                    if (item.cmd == CMD_PULSE) begin
                        for (int i = 0; i < OUTPUT_COUNT; i++) begin
                            if (idx_hot[i]) begin
                                pulse_next[i] = pulse_len;
                            end
                        end
                    end
                end
            end
            CMD_ALL_ON: begin
                auto_next  = 1'b0;
                level_next = '1;
            end
            CMD_ALL_OFF: begin
                auto_next  = 1'b0;
                level_next = '0;
            end
            CMD_RESUME: begin
                if (!auto_reg) begin
                    auto_next     = 1'b1;
                    walk_next     = WALK_W'(1);
                    phase_next    = 1'b0;
                    count_next    = '0;
                    level_next[0] = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= OUTPUT_COUNT'(1);
            auto_reg  <= 1'b1;
            walk_reg  <= WALK_W'(1);
            phase_reg <= 1'b0;
            count_reg <= '0;
            for (int i = 0; i < OUTPUT_COUNT; i++) begin
                pulse_reg[i] <= '0;
            end
        end else if (advance) begin
            level_reg <= level_next;
            auto_reg  <= auto_next;
            walk_reg  <= walk_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            pulse_reg <= pulse_next;
        end
    end

    assign res_levels = level_next;
    assign res_auto   = auto_next;
    assign res_walk   = walk_next[INDEX_W-1:0];
    assign res_status = status;

endmodule

// File: src/ots_output_stage.sv
// ----------------------------------------------------------------------------
// ots_output_stage
// Result register: packs one result transaction and holds it until taken.
// ----------------------------------------------------------------------------
module ots_output_stage
    import ots_pkg::*;
#(
    parameter int OUTPUT_COUNT = OUTPUT_COUNT_DEFAULT,
    parameter int OUT_DATA_W   = ((OUTPUT_COUNT + INDEX_W + 2 + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  logic [OUTPUT_COUNT-1:0] res_levels,
    input  logic                    res_auto,
    input  logic [INDEX_W-1:0]      res_walk,
    input  logic                    res_status,
    output logic                    out_ready,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_DATA_W-1:0]   m_tdata
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [OUT_DATA_W-1:0] data_reg;
    logic [OUT_DATA_W-1:0] data_next;

    assign out_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = data_reg;
    assign data_next = OUT_DATA_W'({res_status, res_walk, res_auto, res_levels});

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: src/output_test_sequencer.sv
// ----------------------------------------------------------------------------
// output_test_sequencer
// Test sequencer for a bank of digital outputs: auto walk, manual and pulse commands.
// ----------------------------------------------------------------------------
// Input stream (s_): one transaction per 1 ms tick or decoded command.
// Result stream (m_): one transaction per input transaction, in order, carrying
// the output levels, walk state and command status after that transaction.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 on_ticks,
// 1 off_ticks, 2 default pulse length, 3 max pulse length); write only when idle.
// Path: input register, state update, then the result register driving m_tvalid.
// Throughput: one transaction per cycle while m_tready is high; the input register,
// the combinational state update and the result register form a two-stage pipeline.
// Reset (aresetn low, synchronous): output 1 on, auto walk running at output 1,
// pulse counters cleared, configuration back to defaults, both stages empty.
// Receiver stall: the result register holds; one more transaction waits in the
// input register, then s_tready drops until m_tready returns.
// ----------------------------------------------------------------------------
module output_test_sequencer
    import ots_pkg::*;
#(
    parameter  int OUTPUT_COUNT = OUTPUT_COUNT_DEFAULT,
    localparam int OUT_DATA_W   = ((OUTPUT_COUNT + INDEX_W + 2 + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // cmd, output_index, pulse_length
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // output_levels, auto_active, walk_position, status
);

    logic                    item_valid;
    item_t                   item;
    logic                    out_ready;
    logic                    advance;
    logic [OUTPUT_COUNT-1:0] res_levels;
    logic                    res_auto;
    logic [INDEX_W-1:0]      res_walk;
    logic                    res_status;

    assign advance = item_valid && out_ready;

    ots_input_stage u_input (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .consume    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ots_core #(
        .OUTPUT_COUNT (OUTPUT_COUNT)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .advance    (advance),
        .item       (item),
        .res_levels (res_levels),
        .res_auto   (res_auto),
        .res_walk   (res_walk),
        .res_status (res_status)
    );

    ots_output_stage #(
        .OUTPUT_COUNT (OUTPUT_COUNT),
        .OUT_DATA_W   (OUT_DATA_W)
    ) u_output (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .res_levels (res_levels),
        .res_auto   (res_auto),
        .res_walk   (res_walk),
        .res_status (res_status),
        .out_ready  (out_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// File: src/ots_checker.sv
// ----------------------------------------------------------------------------
// ots_checker
// Port-level checks of the sequencer's pipeline timing and result channel.
// ----------------------------------------------------------------------------
`include "output_test_sequencer_assert.svh"

module ots_checker
    import ots_pkg::*;
#(
    parameter int OUTPUT_COUNT = OUTPUT_COUNT_DEFAULT,
    parameter int OUT_DATA_W   = ((OUTPUT_COUNT + INDEX_W + 2 + 7) / 8) * 8
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    `OTS_ASSERT_ALW(a_reset_empties, aclk, !aresetn, !m_tvalid)

    `OTS_ASSERT_NXT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))

    `OTS_ASSERT_NXT(a_stall_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    `OTS_ASSERT_IMP(a_result_latency, aclk, aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

    `OTS_ASSERT_NXT(a_full_blocks, aclk, aresetn, m_tvalid && !s_tready, m_tready || !s_tready)

endmodule

bind output_test_sequencer ots_checker #(
    .OUTPUT_COUNT (OUTPUT_COUNT),
    .OUT_DATA_W   (OUT_DATA_W)
) u_ots_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Output test sequencer testbench
// Drives ticks and manual commands into the sequencer over several timing and
// pulse settings. A scoreboard predicts the output levels, walk state and
// status of every transaction and checks each result field by field.
// ----------------------------------------------------------------------------
module tb;
    import ots_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N          = OUTPUT_COUNT_DEFAULT;
    localparam int OUT_W      = ((N + INDEX_W + 2 + 7) / 8) * 8;
    localparam int QUIET_MAX  = 2000;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 300;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    typedef struct packed {
        logic               status;
        logic [INDEX_W-1:0] walk_position;
        logic               auto_active;
        logic [N-1:0]       output_levels;
    } levels_t;

    class level_scoreboard_t;
        logic [PHASE_W-1:0] on_ticks;
        logic [PHASE_W-1:0] off_ticks;
        logic [PULSE_W-1:0] dflt_pulse;
        logic [PULSE_W-1:0] max_pulse;
        logic [N-1:0]       levels;
        logic               walking;
        logic [INDEX_W-1:0] walk_at;
        logic               in_off;
        logic [PHASE_W-1:0] phase_cnt;
        logic [PULSE_W-1:0] pulse_left [N];
        levels_t            expected_levels [$];
        int                 errors;

        function new();
            on_ticks   = ON_TICKS_RESET;
            off_ticks  = OFF_TICKS_RESET;
            dflt_pulse = DEFAULT_PULSE_RESET;
            max_pulse  = MAX_PULSE_RESET;
            levels     = N'(1);
            walking    = 1'b1;
            walk_at    = INDEX_W'(1);
            in_off     = 1'b0;
            phase_cnt  = '0;
            foreach (pulse_left[i]) pulse_left[i] = '0;
            errors     = 0;
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
            case (addr)
                REG_ON_TICKS:      on_ticks = value;
                REG_OFF_TICKS:     off_ticks = value;
                REG_DEFAULT_PULSE: dflt_pulse = value[PULSE_W-1:0];
                REG_MAX_PULSE:     max_pulse = value[PULSE_W-1:0];
                default: ;
            endcase
        endfunction

        function void advance_tick();
            for (int i = 0; i < N; i++) begin
                if (pulse_left[i] != '0) begin
                    pulse_left[i] = pulse_left[i] - PULSE_W'(1);
                    if (pulse_left[i] == '0) levels[i] = 1'b0;
                end
            end
            if (!walking) return;
            phase_cnt = phase_cnt + PHASE_W'(1);
            if (!in_off) begin
                if (phase_cnt >= on_ticks || phase_cnt == '0) begin
                    levels[walk_at - INDEX_W'(1)] = 1'b0;
                    in_off = 1'b1;
                    phase_cnt = '0;
                end
            end else if (phase_cnt >= off_ticks || phase_cnt == '0) begin
                walk_at = (walk_at >= INDEX_W'(N)) ? INDEX_W'(1) : walk_at + INDEX_W'(1);
                levels[walk_at - INDEX_W'(1)] = 1'b1;
                in_off = 1'b0;
                phase_cnt = '0;
            end
        endfunction

        function void note_command(item_t it);
            logic               status;
            logic [REQ_W-1:0]   len;
            logic [INDEX_W-1:0] pos;
            levels_t            want;
            status = 1'b0;
            pos = it.output_index - INDEX_W'(1);
            case (it.cmd)
                CMD_TICK: advance_tick();
                CMD_ON, CMD_OFF, CMD_PULSE: begin
                    if (it.output_index == '0 || it.output_index > INDEX_W'(N)) begin
                        status = 1'b1;
                    end else begin
                        if (walking) begin
                            walking = 1'b0;
                            levels = '0;
                        end
                        if (it.cmd == CMD_ON) begin
                            levels[pos] = 1'b1;
                        end else if (it.cmd == CMD_OFF) begin
                            levels[pos] = 1'b0;
                        end else begin
                            len = it.pulse_length;
                            if (len == '0 || len > REQ_W'(max_pulse)) len = REQ_W'(dflt_pulse);
                            if (len == '0) len = REQ_W'(1);
                            pulse_left[pos] = len[PULSE_W-1:0];
                            levels[pos] = 1'b1;
                        end
                    end
                end
                CMD_ALL_ON: begin
                    walking = 1'b0;
                    levels = '1;
                end
                CMD_ALL_OFF: begin
                    walking = 1'b0;
                    levels = '0;
                end
                CMD_RESUME: begin
                    if (!walking) begin
                        walking = 1'b1;
                        walk_at = INDEX_W'(1);
                        in_off = 1'b0;
                        phase_cnt = '0;
                        levels[0] = 1'b1;
                    end
                end
                default: ;
            endcase
            want.status = status;
            want.walk_position = walk_at;
            want.auto_active = walking;
            want.output_levels = levels;
            expected_levels.push_back(want);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_levels(logic [OUT_W-1:0] raw);
            levels_t got;
            levels_t want;
            got = raw[$bits(levels_t)-1:0];
            if (expected_levels.size() == 0) begin
                report($sformatf("result %h with no transaction pending", raw));
                return;
            end
            want = expected_levels.pop_front();
            if (got.output_levels !== want.output_levels)
                report($sformatf("output_levels %b, want %b",
                                 got.output_levels, want.output_levels));
            if (got.auto_active !== want.auto_active)
                report($sformatf("auto_active %b, want %b",
                                 got.auto_active, want.auto_active));
            if (got.walk_position !== want.walk_position)
                report($sformatf("walk_position %0d, want %0d",
                                 got.walk_position, want.walk_position));
            if (got.status !== want.status)
                report($sformatf("status %b, want %b", got.status, want.status));
        endtask
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;

    bit                    jitter_on = 1'b1;
    int                    quiet     = 0;
    int                    results   = 0;
    level_scoreboard_t     sb        = new();

    output_test_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_MAX) begin
                $display("** output_test_sequencer: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            m_tready <= !jitter_on || ($urandom_range(0, 99) >= 32);
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                sb.check_levels(m_tdata);
                results++;
                if (results == HOLD_AT) begin
                    m_tready <= 1'b0;
                    repeat (HOLD_LEN) @(posedge aclk);
                end
            end
        end
    end

    task automatic send_item(input item_t it);
        while (jitter_on && $urandom_range(0, 99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(it);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_command(it);
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input int idx, input int len);
        item_t it;
        it.cmd = cmd;
        it.output_index = INDEX_W'(idx);
        it.pulse_length = REQ_W'(len);
        send_item(it);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_reg(addr, value);
    endtask

    function automatic item_t random_item(int tick_pct, int pulse_top);
        item_t it;
        int    r;
        r = $urandom_range(0, 99);
        it.output_index = INDEX_W'($urandom);
        it.pulse_length = REQ_W'($urandom);
        if (r < tick_pct) begin
            it.cmd = CMD_TICK;
            return it;
        end
        r = $urandom_range(0, 99);
        if (r < 20)      it.cmd = CMD_ON;
        else if (r < 40) it.cmd = CMD_OFF;
        else if (r < 65) it.cmd = CMD_PULSE;
        else if (r < 73) it.cmd = CMD_ALL_ON;
        else if (r < 81) it.cmd = CMD_ALL_OFF;
        else if (r < 97) it.cmd = CMD_RESUME;
        else             it.cmd = CMD_UNUSED;
        r = $urandom_range(0, 99);
        if (r < 90) begin
            it.output_index = INDEX_W'($urandom_range(1, N));
        end else begin
            it.output_index = INDEX_W'($urandom_range(0, 5));
            if (it.output_index != '0) it.output_index = it.output_index + INDEX_W'(N);
        end
        r = $urandom_range(0, 99);
        if (r < 60)      it.pulse_length = REQ_W'($urandom_range(0, pulse_top));
        else if (r < 75) it.pulse_length = '0;
        return it;
    endfunction

    task automatic run_phase(input logic [CFG_DATA_W-1:0] on_v,
                             input logic [CFG_DATA_W-1:0] off_v,
                             input logic [CFG_DATA_W-1:0] dflt_v,
                             input logic [CFG_DATA_W-1:0] max_v,
                             input int count, input int tick_pct);
        int top;
        drain();
        write_reg(REG_ON_TICKS, on_v);
        write_reg(REG_OFF_TICKS, off_v);
        write_reg(REG_DEFAULT_PULSE, dflt_v);
        write_reg(REG_MAX_PULSE, max_v);
        cfg_we <= 1'b0;
        top = int'(max_v[PULSE_W-1:0]) + 3;
        repeat (count) send_item(random_item(tick_pct, top));
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_cmd(CMD_TICK, 0, 0);
        send_cmd(CMD_RESUME, 0, 0);
        send_cmd(CMD_UNUSED, 15, 16'hFFFF);
        send_cmd(CMD_ON, 0, 0);
        send_cmd(CMD_ON, 15, 0);
        send_cmd(CMD_OFF, 11, 0);
        send_cmd(CMD_PULSE, 0, 5);
        send_cmd(CMD_ON, N, 0);
        send_cmd(CMD_ON, 1, 0);
        send_cmd(CMD_OFF, N, 0);
        send_cmd(CMD_PULSE, 5, 0);
        send_cmd(CMD_PULSE, 6, 16'hFFFF);
        send_cmd(CMD_PULSE, 7, 10000);
        send_cmd(CMD_PULSE, 7, 10001);
        send_cmd(CMD_PULSE, 3, 1);
        send_cmd(CMD_TICK, 0, 0);
        send_cmd(CMD_ALL_ON, 15, 0);
        send_cmd(CMD_ALL_OFF, 15, 0);
        send_cmd(CMD_RESUME, 0, 0);
        send_cmd(CMD_TICK, 0, 0);
        send_cmd(CMD_PULSE, 2, 2);
        send_cmd(CMD_ON, 9, 0);
        send_cmd(CMD_RESUME, 0, 0);
        send_cmd(CMD_TICK, 0, 0);

        run_phase(1, 1, 3, 5, 160, 60);
        run_phase(0, 0, 0, 0, 160, 60);
        jitter_on = 1'b0;
        run_phase(3, 2, 7, 16'hFFFF, 160, 70);
        jitter_on = 1'b1;
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16383, 60, 50);
        repeat (5) begin
            run_phase(CFG_DATA_W'($urandom_range(1, 8)), CFG_DATA_W'($urandom_range(1, 8)),
                      CFG_DATA_W'($urandom_range(0, 20)), CFG_DATA_W'($urandom_range(0, 30)),
                      130, 75);
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** output_test_sequencer: PASSED **");
        end else begin
            $display("** output_test_sequencer: FAILED **");
        end
        $finish;
    end
endmodule
